// File: design/date_validate_compare_difference_top_defines.svh
// assertion macros used by the date pair comparator top level
`ifndef DATE_VALIDATE_COMPARE_DIFFERENCE_TOP_DEFINES_SVH
`define DATE_VALIDATE_COMPARE_DIFFERENCE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked at every rising clk edge outside reset
`define DVCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising clk edge outside reset
`define DVCD_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`else

`define DVCD_ASSERT(label, prop, msg)
`define DVCD_ASSERT_IMPLY(label, cond, prop, msg)

`endif

`endif

// File: design/dvcd_pkg.sv
// types, constants and calendar tables for the date pair comparator
`default_nettype none

package dvcd_pkg;

    // field widths
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DNUM_W  = 22;
    localparam int unsigned Q100_W  = 7;
    localparam int unsigned MOFF_W  = 9;

    // accepted year range
    localparam logic [YEAR_W-1:0] MIN_YEAR = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

    // replacement date for a failed check
    localparam logic [YEAR_W-1:0]  FALLBACK_YEAR  = YEAR_W'(1900);
    localparam logic [MONTH_W-1:0] FALLBACK_MONTH = MONTH_W'(1);
    localparam logic [DAY_W-1:0]   FALLBACK_DAY   = DAY_W'(1);

    // month codes used in the logic
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // floor(y / 100) for y below 2**14 is (y * 5243) >> 19
    localparam int unsigned         RECIP100_SHIFT = 19;
    localparam logic [12:0]         RECIP100       = 13'd5243;

    localparam logic [8:0]          DAYS_PER_YEAR  = 9'd365;
    localparam logic [6:0]          CENTURY        = 7'd100;

    // per-stage load enables of the date path
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
        logic load_d;
    } stage_en_t;

    // length of a common year month, month codes 1 to 12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days before month mp of a march-based year, (153 * mp + 2) / 5
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] mp);
        logic [MOFF_W-1:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// File: design/date_validate_compare_difference_top.sv
// top level: date pair check, compare and day difference pipeline
//
// channel  dir  tdata fields (low bit first)
// s_axis   in   first_day[4:0] first_month[8:5] first_year[22:9]
//               second_day[27:23] second_month[31:28] second_year[45:32], zero fill to 48
// m_axis   out  day_count[21:0] first_valid[22] second_valid[23]
//               first_earlier[24] dates_equal[25], zero fill to 32
//
// one date pair enters per cycle while m_tready does not stall the stages; its result
// passes through four stages of the per-date path (two multiplies by a reciprocal of
// 100 and the day number sum) and then the compare / output register
// each stage loads when it is empty or the stage after it moves, so a stall on
// m_tready backs up through the stages without loss or repeat
// rst_n clears the stage valid bits only; no clearing pass is needed
`default_nettype none

`include "date_validate_compare_difference_top_defines.svh"

module date_validate_compare_difference_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // first_day, first_month, first_year, second_day,
                                        // second_month, second_year, zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // day_count, first_valid, second_valid,
                                        // first_earlier, dates_equal, zero fill
);

    localparam int unsigned PATH_STAGES = 4;

    // input field split
    logic [dvcd_pkg::DAY_W-1:0]   first_day;
    logic [dvcd_pkg::MONTH_W-1:0] first_month;
    logic [dvcd_pkg::YEAR_W-1:0]  first_year;
    logic [dvcd_pkg::DAY_W-1:0]   second_day;
    logic [dvcd_pkg::MONTH_W-1:0] second_month;
    logic [dvcd_pkg::YEAR_W-1:0]  second_year;

    assign first_day    = s_tdata[4:0];
    assign first_month  = s_tdata[8:5];
    assign first_year   = s_tdata[22:9];
    assign second_day   = s_tdata[27:23];
    assign second_month = s_tdata[31:28];
    assign second_year  = s_tdata[45:32];

    // stage valid bits and load enables
    logic [PATH_STAGES-1:0] vld_reg;
    logic [PATH_STAGES-1:0] vld_next;
    logic [PATH_STAGES-1:0] load;
    logic                   out_vld_reg;
    logic                   out_vld_next;
    logic                   out_load;
    dvcd_pkg::stage_en_t    path_en;

    always_comb
    begin
        out_load                = !out_vld_reg || m_tready;
        load[PATH_STAGES-1]     = !vld_reg[PATH_STAGES-1] || out_load;
        for (int i = PATH_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
        vld_next[0] = load[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < PATH_STAGES; i++)
        begin
            vld_next[i] = load[i] ? vld_reg[i-1] : vld_reg[i];
        end
        out_vld_next = out_load ? vld_reg[PATH_STAGES-1] : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign path_en.load_a = load[0];
    assign path_en.load_b = load[1];
    assign path_en.load_c = load[2];
    assign path_en.load_d = load[3];

    // one date path per date
    logic                        first_ok;
    logic                        second_ok;
    logic [dvcd_pkg::DNUM_W-1:0] first_num;
    logic [dvcd_pkg::DNUM_W-1:0] second_num;

    dvcd_date_path u_first_path
    (
        .clk        (clk),
        .en         (path_en),
        .day        (first_day),
        .month      (first_month),
        .year       (first_year),
        .date_valid (first_ok),
        .day_num    (first_num)
    );

    dvcd_date_path u_second_path
    (
        .clk        (clk),
        .en         (path_en),
        .day        (second_day),
        .month      (second_month),
        .year       (second_year),
        .date_valid (second_ok),
        .day_num    (second_num)
    );

    // compare and absolute difference into the output register
    logic [dvcd_pkg::DNUM_W-1:0] day_count_reg;
    logic                        first_valid_reg;
    logic                        second_valid_reg;
    logic                        first_earlier_reg;
    logic                        dates_equal_reg;
    logic [dvcd_pkg::DNUM_W-1:0] day_count_next;
    logic                        first_earlier_next;

    always_comb
    begin
        first_earlier_next = first_num < second_num;
        day_count_next     = first_earlier_next ? (second_num - first_num)
                                                : (first_num - second_num);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            day_count_reg     <= day_count_next;
            first_valid_reg   <= first_ok;
            second_valid_reg  <= second_ok;
            first_earlier_reg <= first_earlier_next;
            dates_equal_reg   <= (first_num == second_num);
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, dates_equal_reg, first_earlier_reg, second_valid_reg,
                       first_valid_reg, day_count_reg};

    // checks
    `DVCD_ASSERT_IMPLY(a_equal_means_zero, m_tvalid && dates_equal_reg,
        (day_count_reg == '0) && !first_earlier_reg, "equal dates with nonzero difference")
    `DVCD_ASSERT_IMPLY(a_both_invalid_equal, m_tvalid && !first_valid_reg && !second_valid_reg,
        dates_equal_reg, "two replaced dates not reported equal")
    `DVCD_ASSERT_IMPLY(a_stall_only_when_full, !s_tready,
        m_tvalid && !m_tready, "input stalled while output can move")
    `DVCD_ASSERT_IMPLY(a_nonzero_not_equal, m_tvalid && (day_count_reg != '0),
        !dates_equal_reg, "nonzero difference reported equal")

endmodule

`default_nettype wire

// File: design/dvcd_date_path.sv
// four-stage check and serial day number path for one date
`default_nettype none

module dvcd_date_path
(
    input  wire logic                           clk,
    input  wire dvcd_pkg::stage_en_t            en,
    input  wire logic [dvcd_pkg::DAY_W-1:0]     day,
    input  wire logic [dvcd_pkg::MONTH_W-1:0]   month,
    input  wire logic [dvcd_pkg::YEAR_W-1:0]    year,
    output logic                                date_valid,
    output logic [dvcd_pkg::DNUM_W-1:0]         day_num
);

    // stage a: range checks and year / 100
    logic [dvcd_pkg::DAY_W-1:0]   a_day_reg;
    logic [dvcd_pkg::MONTH_W-1:0] a_month_reg;
    logic [dvcd_pkg::YEAR_W-1:0]  a_year_reg;
    logic [dvcd_pkg::Q100_W-1:0]  a_q100_reg;
    logic                         a_range_ok_reg;
    logic [dvcd_pkg::Q100_W-1:0]  a_q100_next;
    logic                         a_range_ok_next;
    logic [26:0]                  a_prod;

    always_comb
    begin
        a_prod          = 27'(year) * 27'(dvcd_pkg::RECIP100);
        a_q100_next     = a_prod[dvcd_pkg::RECIP100_SHIFT +: dvcd_pkg::Q100_W];
        a_range_ok_next = (year >= dvcd_pkg::MIN_YEAR) && (year <= dvcd_pkg::MAX_YEAR)
                       && (month >= dvcd_pkg::MONTH_JAN) && (month <= dvcd_pkg::MONTH_DEC)
                       && (day != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            a_day_reg      <= day;
            a_month_reg    <= month;
            a_year_reg     <= year;
            a_q100_reg     <= a_q100_next;
            a_range_ok_reg <= a_range_ok_next;
        end
    end

    // stage b: leap rule, month length, replacement and march-based shift
    logic                         b_valid_reg;
    logic [dvcd_pkg::DAY_W-1:0]   b_day_reg;
    logic [dvcd_pkg::MONTH_W-1:0] b_mp_reg;
    logic [dvcd_pkg::YEAR_W-1:0]  b_yy_reg;
    logic                         b_valid_next;
    logic [dvcd_pkg::DAY_W-1:0]   b_day_next;
    logic [dvcd_pkg::MONTH_W-1:0] b_mp_next;
    logic [dvcd_pkg::YEAR_W-1:0]  b_yy_next;
    logic [dvcd_pkg::YEAR_W-1:0]  b_rem100;
    logic                         b_leap;
    logic [dvcd_pkg::DAY_W-1:0]   b_lim;
    logic [dvcd_pkg::MONTH_W-1:0] b_m;
    logic [dvcd_pkg::YEAR_W-1:0]  b_y;

    always_comb
    begin
        b_rem100 = a_year_reg
                 - dvcd_pkg::YEAR_W'(dvcd_pkg::YEAR_W'(a_q100_reg)
                                     * dvcd_pkg::YEAR_W'(dvcd_pkg::CENTURY));
        // divisible by 400 means divisible by 100 with a quotient divisible by 4
        b_leap   = (a_year_reg[1:0] == 2'b00)
                && ((b_rem100 != '0) || (a_q100_reg[1:0] == 2'b00));
        b_lim    = dvcd_pkg::month_len(a_month_reg);
        if (b_leap && (a_month_reg == dvcd_pkg::MONTH_FEB))
        begin
            b_lim = dvcd_pkg::DAY_W'(29);
        end
        b_valid_next = a_range_ok_reg && (a_day_reg <= b_lim);
        if (b_valid_next)
        begin
            b_day_next = a_day_reg;
            b_m        = a_month_reg;
            b_y        = a_year_reg;
        end
        else
        begin
            b_day_next = dvcd_pkg::FALLBACK_DAY;
            b_m        = dvcd_pkg::FALLBACK_MONTH;
            b_y        = dvcd_pkg::FALLBACK_YEAR;
        end
        if (b_m <= dvcd_pkg::MONTH_FEB)
        begin
            b_yy_next = b_y - dvcd_pkg::YEAR_W'(1);
            b_mp_next = b_m + dvcd_pkg::MONTH_W'(9);
        end
        else
        begin
            b_yy_next = b_y;
            b_mp_next = b_m - dvcd_pkg::MONTH_W'(3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            b_valid_reg <= b_valid_next;
            b_day_reg   <= b_day_next;
            b_mp_reg    <= b_mp_next;
            b_yy_reg    <= b_yy_next;
        end
    end

    // stage c: year part, century count and month offset
    logic                          c_valid_reg;
    logic [dvcd_pkg::DAY_W-1:0]    c_day_reg;
    logic [dvcd_pkg::DNUM_W-1:0]   c_years_reg;
    logic [dvcd_pkg::Q100_W-1:0]   c_q100_reg;
    logic [dvcd_pkg::MOFF_W-1:0]   c_moff_reg;
    logic [dvcd_pkg::DNUM_W-1:0]   c_years_next;
    logic [dvcd_pkg::Q100_W-1:0]   c_q100_next;
    logic [26:0]                   c_prod;

    always_comb
    begin
        c_prod       = 27'(b_yy_reg) * 27'(dvcd_pkg::RECIP100);
        c_q100_next  = c_prod[dvcd_pkg::RECIP100_SHIFT +: dvcd_pkg::Q100_W];
        c_years_next = dvcd_pkg::DNUM_W'(b_yy_reg) * dvcd_pkg::DNUM_W'(dvcd_pkg::DAYS_PER_YEAR)
                     + dvcd_pkg::DNUM_W'(b_yy_reg[dvcd_pkg::YEAR_W-1:2]);
    end

    always_ff @(posedge clk)
    begin
        if (en.load_c)
        begin
            c_valid_reg <= b_valid_reg;
            c_day_reg   <= b_day_reg;
            c_years_reg <= c_years_next;
            c_q100_reg  <= c_q100_next;
            c_moff_reg  <= dvcd_pkg::month_offset(b_mp_reg);
        end
    end

    // stage d: serial day number
    logic                        d_valid_reg;
    logic [dvcd_pkg::DNUM_W-1:0] d_num_reg;
    logic [dvcd_pkg::DNUM_W-1:0] d_num_next;

    always_comb
    begin
        d_num_next = c_years_reg
                   - dvcd_pkg::DNUM_W'(c_q100_reg)
                   + dvcd_pkg::DNUM_W'(c_q100_reg[dvcd_pkg::Q100_W-1:2])
                   + dvcd_pkg::DNUM_W'(c_moff_reg)
                   + dvcd_pkg::DNUM_W'(c_day_reg)
                   - dvcd_pkg::DNUM_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en.load_d)
        begin
            d_valid_reg <= c_valid_reg;
            d_num_reg   <= d_num_next;
        end
    end

    assign date_valid = d_valid_reg;
    assign day_num    = d_num_reg;

endmodule

`default_nettype wire
